### rtl/core/pgm_stream_decoder_core_assert.svh
// Assertion macros for the PGM stream decoder checker
`ifndef PGM_STREAM_DECODER_CORE_ASSERT_SVH
`define PGM_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/psd_pkg.sv
// Types and constants shared by the PGM stream decoder files
package psd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 16;
    localparam int ERR_W   = 3;
    localparam int SUM_W   = 40;
    localparam int ACC_W   = 17;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam logic [ACC_W-1:0]   ACC_SAT    = 17'd65536;
    localparam logic [ACC_W-1:0]   MAXVAL_TOP = 17'd65535;
    localparam logic [ACC_W-1:0]   NARROW_TOP = 17'd255;
    localparam logic [VALUE_W-1:0] ALL_ONES   = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
    localparam logic [BYTE_W-1:0] CH_2     = 8'h32;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [KIND_W-1:0] {
        KIND_WIDTH  = 3'd0,
        KIND_HEIGHT = 3'd1,
        KIND_MAXVAL = 3'd2,
        KIND_PIXEL  = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_MAGIC     = 3'd0,
        ERR_SIZE      = 3'd1,
        ERR_MAXVAL    = 3'd2,
        ERR_TOKEN     = 3'd3,
        ERR_EARLY_END = 3'd4
    } err_t;

    typedef enum logic [7:0] {
        PH_MAGIC0 = 8'b0000_0001,
        PH_MAGIC1 = 8'b0000_0010,
        PH_WIDTH  = 8'b0000_0100,
        PH_HEIGHT = 8'b0000_1000,
        PH_MAXVAL = 8'b0001_0000,
        PH_PIXELS = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } phase_t;

endpackage

### rtl/core/pgm_stream_decoder_core.sv
// A byte's result reaches the outputs through the input register and then the result register.
// Throughput: one byte per cycle while the result is not stalled; the input register and the result register
//   are the only pipeline stages, and a stalled result holds the input stage.
// A byte that yields no result leaves the result register empty.
// Reset (rst_n low, asynchronous) returns the parser to the first magic byte
//   and empties both stages; end_of_stream does the same for the parser.
module pgm_stream_decoder_core #(
    parameter int MAX_DIM = psd_pkg::MAX_DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [psd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        end_of_stream,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [psd_pkg::KIND_W-1:0]  kind,
    output logic [psd_pkg::VALUE_W-1:0] value,
    output logic [psd_pkg::ERR_W-1:0]   error_code,
    output logic                        last_pixel,
    output logic [psd_pkg::VALUE_W-1:0] min_value,
    output logic [psd_pkg::VALUE_W-1:0] max_value,
    output logic [psd_pkg::SUM_W-1:0]   pixel_sum
);
    import psd_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int LEFT_W = 2 * DIM_W;
    localparam logic [ACC_W-1:0] DIM_TOP = ACC_W'(MAX_DIM);

    // input stage
    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               s1_eos_reg;

    // parser state
    phase_t             phase_reg, phase_next;
    logic               ascii_reg, ascii_next;
    logic               comment_reg, comment_next;
    logic               token_reg, token_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               wide_reg, wide_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0]  high_reg, high_next;
    logic               half_reg, half_next;
    logic [VALUE_W-1:0] min_reg, min_next;
    logic [VALUE_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    // result stage
    logic               res_valid_reg;
    kind_t              res_kind_reg, res_kind_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    err_t               res_err_reg, res_err_next;
    logic               res_last_reg, res_last_next;
    logic [VALUE_W-1:0] res_min_reg, res_min_next;
    logic [VALUE_W-1:0] res_max_reg, res_max_next;
    logic [SUM_W-1:0]   res_sum_reg, res_sum_next;
    logic               res_fire;

    logic               advance;
    logic               accept;
    logic               go;

    logic               is_digit;
    logic               is_space;
    logic [ACC_W+3:0]   acc_mul;
    logic [LEFT_W-1:0]  area;
    logic               tok_fire;
    logic               pix_fire;
    logic [VALUE_W-1:0] pix_val;
    logic               fail_fire;
    err_t               fail_code;
    logic [ACC_W-1:0]   capped;
    logic [VALUE_W-1:0] new_min;
    logic [VALUE_W-1:0] new_max;
    logic [SUM_W-1:0]   new_sum;

    assign advance    = !res_valid_reg || !result_stall;
    assign byte_stall = s1_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;
    assign go         = s1_valid_reg && advance;

    assign is_digit = (s1_byte_reg >= CH_ZERO) && (s1_byte_reg <= CH_NINE);
    assign is_space = (s1_byte_reg == CH_SPACE) ||
                      ((s1_byte_reg >= CH_TAB) && (s1_byte_reg <= CH_CR));
    assign acc_mul  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                      + (ACC_W+4)'(s1_byte_reg[3:0]);
    assign area     = LEFT_W'(width_reg) * LEFT_W'(height_reg);
    assign capped   = wide_reg ? ((acc_reg > MAXVAL_TOP) ? MAXVAL_TOP : acc_reg)
                               : ((acc_reg > NARROW_TOP) ? NARROW_TOP : acc_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        ascii_next   = ascii_reg;
        comment_next = comment_reg;
        token_next   = token_reg;
        acc_next     = acc_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        wide_next    = wide_reg;
        left_next    = left_reg;
        high_next    = high_reg;
        half_next    = half_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;

        res_fire       = 1'b0;
        res_kind_next  = KIND_WIDTH;
        res_value_next = '0;
        res_err_next   = ERR_MAGIC;
        res_last_next  = 1'b0;
        res_min_next   = '0;
        res_max_next   = '0;
        res_sum_next   = '0;

        tok_fire  = 1'b0;
        pix_fire  = 1'b0;
        pix_val   = '0;
        fail_fire = 1'b0;
        fail_code = ERR_MAGIC;
        new_min   = min_reg;
        new_max   = max_reg;
        new_sum   = sum_reg;

        // decode the byte
        if (go)
        begin
            if (s1_eos_reg)
            begin
                if (phase_reg == PH_PIXELS && ascii_reg && token_reg &&
                    left_reg == '0 && !comment_reg)
                begin
                    tok_fire = 1'b1;
                end
                else if (phase_reg != PH_DONE && phase_reg != PH_ERROR)
                begin
                    fail_fire = 1'b1;
                    fail_code = ERR_EARLY_END;
                end
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_DONE, PH_ERROR:
                    begin
                    end
                    PH_MAGIC0:
                    begin
                        if (s1_byte_reg != CH_P)
                        begin
                            fail_fire = 1'b1;
                            fail_code = ERR_MAGIC;
                        end
                        else
                        begin
                            phase_next = PH_MAGIC1;
                        end
                    end
                    PH_MAGIC1:
                    begin
                        if (s1_byte_reg == CH_5)
                        begin
                            ascii_next = 1'b0;
                            phase_next = PH_WIDTH;
                        end
                        else if (s1_byte_reg == CH_2)
                        begin
                            ascii_next = 1'b1;
                            phase_next = PH_WIDTH;
                        end
                        else
                        begin
                            fail_fire = 1'b1;
                            fail_code = ERR_MAGIC;
                        end
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS:
                    begin
                        if (comment_reg)
                        begin
                            if (s1_byte_reg == CH_LF || s1_byte_reg == CH_CR)
                            begin
                                comment_next = 1'b0;
                            end
                        end
                        else if (phase_reg == PH_PIXELS && !ascii_reg)
                        begin
                            if (!wide_reg)
                            begin
                                pix_fire = 1'b1;
                                pix_val  = VALUE_W'(s1_byte_reg);
                            end
                            else if (!half_reg)
                            begin
                                high_next = s1_byte_reg;
                                half_next = 1'b1;
                            end
                            else
                            begin
                                half_next = 1'b0;
                                pix_fire  = 1'b1;
                                pix_val   = {high_reg, s1_byte_reg};
                            end
                        end
                        else if (is_digit)
                        begin
                            acc_next   = (acc_mul > (ACC_W+4)'(ACC_SAT)) ? ACC_SAT
                                                                         : acc_mul[ACC_W-1:0];
                            token_next = 1'b1;
                        end
                        else if (is_space)
                        begin
                            tok_fire = token_reg;
                        end
                        else if (s1_byte_reg == CH_HASH)
                        begin
                            comment_next = 1'b1;
                            tok_fire     = token_reg;
                        end
                        else
                        begin
                            fail_fire = 1'b1;
                            fail_code = ERR_TOKEN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // close a decimal token
        if (tok_fire)
        begin
            token_next = 1'b0;
            acc_next   = '0;
            if (phase_reg == PH_WIDTH || phase_reg == PH_HEIGHT)
            begin
                if (acc_reg == '0 || acc_reg > DIM_TOP)
                begin
                    fail_fire = 1'b1;
                    fail_code = ERR_SIZE;
                end
                else if (phase_reg == PH_WIDTH)
                begin
                    width_next     = acc_reg[DIM_W-1:0];
                    phase_next     = PH_HEIGHT;
                    res_fire       = 1'b1;
                    res_kind_next  = KIND_WIDTH;
                    res_value_next = acc_reg[VALUE_W-1:0];
                end
                else
                begin
                    height_next    = acc_reg[DIM_W-1:0];
                    phase_next     = PH_MAXVAL;
                    res_fire       = 1'b1;
                    res_kind_next  = KIND_HEIGHT;
                    res_value_next = acc_reg[VALUE_W-1:0];
                end
            end
            else if (phase_reg == PH_MAXVAL)
            begin
                if (acc_reg == '0 || acc_reg > MAXVAL_TOP)
                begin
                    fail_fire = 1'b1;
                    fail_code = ERR_MAXVAL;
                end
                else
                begin
                    wide_next      = acc_reg > NARROW_TOP;
                    left_next      = area - LEFT_W'(1);
                    phase_next     = PH_PIXELS;
                    res_fire       = 1'b1;
                    res_kind_next  = KIND_MAXVAL;
                    res_value_next = acc_reg[VALUE_W-1:0];
                end
            end
            else
            begin
                pix_fire = 1'b1;
                pix_val  = capped[VALUE_W-1:0];
            end
        end

        // fold a sample into the statistics
        if (pix_fire)
        begin
            new_min  = (pix_val < min_reg) ? pix_val : min_reg;
            new_max  = (pix_val > max_reg) ? pix_val : max_reg;
            new_sum  = sum_reg + SUM_W'(pix_val);
            min_next = new_min;
            max_next = new_max;
            sum_next = new_sum;
            res_fire       = 1'b1;
            res_kind_next  = KIND_PIXEL;
            res_value_next = pix_val;
            if (left_reg == '0)
            begin
                phase_next    = PH_DONE;
                res_last_next = 1'b1;
                res_min_next  = new_min;
                res_max_next  = new_max;
                res_sum_next  = new_sum;
            end
            else
            begin
                left_next = left_reg - LEFT_W'(1);
            end
        end

        if (fail_fire)
        begin
            phase_next     = PH_ERROR;
            res_fire       = 1'b1;
            res_kind_next  = KIND_ERROR;
            res_value_next = '0;
            res_err_next   = fail_code;
            res_last_next  = 1'b0;
            res_min_next   = '0;
            res_max_next   = '0;
            res_sum_next   = '0;
        end

        // drop all parser state at end of stream
        if (go && s1_eos_reg)
        begin
            phase_next   = PH_MAGIC0;
            ascii_next   = 1'b0;
            comment_next = 1'b0;
            token_next   = 1'b0;
            acc_next     = '0;
            width_next   = '0;
            height_next  = '0;
            wide_next    = 1'b0;
            left_next    = '0;
            high_next    = '0;
            half_next    = 1'b0;
            min_next     = ALL_ONES;
            max_next     = '0;
            sum_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_MAGIC0;
            ascii_reg     <= 1'b0;
            comment_reg   <= 1'b0;
            token_reg     <= 1'b0;
            acc_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            wide_reg      <= 1'b0;
            left_reg      <= '0;
            high_reg      <= '0;
            half_reg      <= 1'b0;
            min_reg       <= ALL_ONES;
            max_reg       <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= go && res_fire;
            end
            phase_reg   <= phase_next;
            ascii_reg   <= ascii_next;
            comment_reg <= comment_next;
            token_reg   <= token_next;
            acc_reg     <= acc_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            wide_reg    <= wide_next;
            left_reg    <= left_next;
            high_reg    <= high_next;
            half_reg    <= half_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_eos_reg  <= end_of_stream;
        end
        if (go && res_fire)
        begin
            res_kind_reg  <= res_kind_next;
            res_value_reg <= res_value_next;
            res_err_reg   <= res_err_next;
            res_last_reg  <= res_last_next;
            res_min_reg   <= res_min_next;
            res_max_reg   <= res_max_next;
            res_sum_reg   <= res_sum_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign value        = res_value_reg;
    assign error_code   = res_err_reg;
    assign last_pixel   = res_last_reg;
    assign min_value    = res_min_reg;
    assign max_value    = res_max_reg;
    assign pixel_sum    = res_sum_reg;

endmodule

### rtl/core/pgm_stream_decoder_core_chk.sv
// Port-level checker for the PGM stream decoder and its bind
`include "pgm_stream_decoder_core_assert.svh"

module pgm_stream_decoder_core_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [psd_pkg::KIND_W-1:0]  kind,
    input logic [psd_pkg::VALUE_W-1:0] value,
    input logic [psd_pkg::ERR_W-1:0]   error_code,
    input logic                        last_pixel,
    input logic [psd_pkg::VALUE_W-1:0] min_value,
    input logic [psd_pkg::VALUE_W-1:0] max_value,
    input logic [psd_pkg::SUM_W-1:0]   pixel_sum
);
    import psd_pkg::*;

    `PSD_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(kind) && $stable(value) && $stable(last_pixel), "stalled result changed")

    `PSD_ASSERT_IMP(a_stats_zero, result_valid && !last_pixel, min_value == '0 && max_value == '0 && pixel_sum == '0, "statistics set on a non-final result")

    `PSD_ASSERT_IMP(a_last_stats, result_valid && last_pixel, kind == KIND_PIXEL && min_value <= value && value <= max_value, "final pixel outside its own statistics")

    `PSD_ASSERT_IMP(a_error_form, result_valid && kind == KIND_ERROR, value == '0 && !last_pixel && error_code <= ERR_EARLY_END, "malformed error result")

endmodule

bind pgm_stream_decoder_core pgm_stream_decoder_core_chk u_chk (.*);
